>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lifecycle monitor
// Concurrent checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define TLM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// expression must never be true
`define TLM_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define TLM_ASSERT(lbl, prop, msg)
`define TLM_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

>>> hw/rtl/tlm_pkg.sv
// ----------------------------------------------------------------------------
// tlm_pkg
// Types, codes and constants shared by the lifecycle monitor modules.
// ----------------------------------------------------------------------------
`default_nettype none
package tlm_pkg;

    localparam int TABLE_SLOTS_DEF = 64;
    localparam int TASK_ROWS_DEF   = 16;
    localparam int NCNT            = 17;
    localparam int TS_W            = 48;
    localparam int HASH_SHIFT      = 33;
    localparam logic [31:0] HASH_LO = 32'hed558ccd;
    localparam logic [31:0] HASH_HI = 32'hff51afd7;

    typedef enum logic [3:0] {
        CMD_QUEUED   = 4'd0,
        CMD_STARTED  = 4'd1,
        CMD_FINISHED = 4'd2,
        CMD_FAILED   = 4'd3,
        CMD_RETRIED  = 4'd4,
        CMD_DEAD     = 4'd5,
        CMD_DROPPED  = 4'd6,
        CMD_READ     = 4'd7,
        CMD_CLEAR    = 4'd8
    } t_cmd;

    typedef enum logic [2:0] {
        HS_NONE, HS_PENDING, HS_RUNNING, HS_LIMBO, HS_DONE
    } t_hstate;

    typedef enum logic [4:0] {
        C_QUEUED, C_STARTED, C_FINISHED, C_FAILED, C_RETRIED, C_DEAD, C_DROPPED,
        C_CANCELLED, C_TERMINAL, C_PENDING, C_INFLIGHT, C_WSAMP, C_WSUM, C_WMAX,
        C_RSAMP, C_RSUM, C_RMAX
    } t_ctr;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_HASH, ST_PRB_RD, ST_PRB_CK, ST_EVAL, ST_RM_NEXT,
        ST_RM_CK, ST_RM_HASH, ST_RM_END, ST_CNT, ST_CLR, ST_RD, ST_RD_WAIT, ST_OUT
    } t_state;

    typedef struct packed {
        logic [3:0] task_id;
        logic       hs;
        logic       hq;
        logic       seen;
        t_hstate    st;
    } t_info;

    typedef struct packed {
        logic [TS_W-1:0] stt;
        logic [TS_W-1:0] qt;
        t_info           info;
        logic [31:0]     key;
    } t_entry;

    // outcome of one lifecycle event
    typedef struct packed {
        t_entry          ent;
        logic            gone;
        logic [NCNT-1:0] en_m;
        logic [NCNT-1:0] dec_m;
        logic            ws;
        logic [TS_W-1:0] wms;
        logic            rs;
        logic [TS_W-1:0] rms;
    } t_evt_res;

endpackage
`default_nettype wire

>>> hw/rtl/tlm_hash.sv
// ----------------------------------------------------------------------------
// tlm_hash
// Home slot of a handle: murmur3 finalizer, 32x32 partial products registered
// low half then high half after the key; o_done marks the result valid.
// ----------------------------------------------------------------------------
`default_nettype none
module tlm_hash #(
    parameter int TABLE_SLOTS = tlm_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [31:0]                    i_key,
    output logic                                o_done,
    output logic [$clog2(TABLE_SLOTS)-1:0]      o_home
);
    import tlm_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    logic [2:0]  r_v;
    logic [31:0] r_key;
    logic [63:0] r_p0;
    logic [31:0] r_p1;
    logic [31:0] hi_prod;
    logic [63:0] prod;
    logic [63:0] mixed;

    // stage valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_start};
        end
    end

    assign hi_prod = r_key * HASH_HI;

    // partial products, low half then high half
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
        end
        if (r_v[0]) begin
            r_p0 <= {32'b0, r_key} * {32'b0, HASH_LO};
        end
        if (r_v[1]) begin
            r_p1 <= hi_prod;
        end
    end

    assign prod   = r_p0 + {r_p1, 32'b0};
    assign mixed  = prod ^ (prod >> HASH_SHIFT);
    assign o_home = mixed[SLOT_W-1:0];
    assign o_done = r_v[2];

endmodule
`default_nettype wire

>>> hw/rtl/tlm_evt.sv
// ----------------------------------------------------------------------------
// tlm_evt
// Per-handle state transition and counter update set for one event.
// ----------------------------------------------------------------------------
`default_nettype none
module tlm_evt (
    input  wire logic [3:0]                 i_cmd,
    input  wire logic                       i_has,
    input  wire logic                       i_canc,
    input  wire logic [tlm_pkg::TS_W-1:0]   i_ts,
    input  wire tlm_pkg::t_entry            i_ent,
    output tlm_pkg::t_evt_res               o_res
);
    import tlm_pkg::*;

    always_comb begin
        t_evt_res r;
        t_hstate  st;
        logic     seen;
        logic     hq;
        logic     hs;
        logic [TS_W-1:0] qt;
        logic [TS_W-1:0] stt;
        logic     fin;

        r    = '0;
        st   = i_ent.info.st;
        seen = i_ent.info.seen;
        hq   = i_ent.info.hq;
        hs   = i_ent.info.hs;
        qt   = i_ent.qt;
        stt  = i_ent.stt;
        fin  = (i_cmd == CMD_FINISHED);

        unique case (t_cmd'(i_cmd))
            CMD_QUEUED: begin
                r.en_m[C_QUEUED] = 1'b1;
                if (i_has) begin
                    seen = 1'b1;
                    if (!hq && hs) begin
                        r.ws  = 1'b1;
                        r.wms = (stt > i_ts) ? stt - i_ts : '0;
                    end
                    if (st == HS_DONE) begin
                        r.gone = 1'b1;
                    end else begin
                        if (st == HS_NONE) begin
                            st = HS_PENDING;
                            r.en_m[C_PENDING] = 1'b1;
                        end
                        if (!hq) begin
                            qt = i_ts;
                            hq = 1'b1;
                        end
                    end
                end
            end
            CMD_STARTED: begin
                r.en_m[C_STARTED] = 1'b1;
                if (i_has) begin
                    if (st == HS_PENDING) begin
                        r.en_m[C_PENDING]  = 1'b1;
                        r.dec_m[C_PENDING] = 1'b1;
                    end
                    st  = HS_RUNNING;
                    stt = i_ts;
                    hs  = 1'b1;
                    r.en_m[C_INFLIGHT] = 1'b1;
                    if (hq && i_ts >= qt) begin
                        r.ws  = 1'b1;
                        r.wms = i_ts - qt;
                    end
                end
            end
            CMD_FINISHED, CMD_FAILED: begin
                if (fin) begin
                    r.en_m[C_FINISHED] = 1'b1;
                    r.en_m[C_TERMINAL] = 1'b1;
                end else begin
                    r.en_m[C_FAILED] = 1'b1;
                    if (i_canc) begin
                        r.en_m[C_CANCELLED] = 1'b1;
                        r.en_m[C_TERMINAL]  = 1'b1;
                    end
                end
                if (i_has) begin
                    if (st == HS_RUNNING) begin
                        r.en_m[C_INFLIGHT]  = 1'b1;
                        r.dec_m[C_INFLIGHT] = 1'b1;
                        if (hs && i_ts >= stt) begin
                            r.rs  = 1'b1;
                            r.rms = i_ts - stt;
                        end
                    end else if (!fin && st == HS_PENDING) begin
                        r.en_m[C_PENDING]  = 1'b1;
                        r.dec_m[C_PENDING] = 1'b1;
                    end
                    if (!fin) begin
                        st = HS_LIMBO;
                    end
                    if (fin || i_canc) begin
                        if (seen) begin
                            r.gone = 1'b1;
                        end else begin
                            st = HS_DONE;
                        end
                    end
                end
            end
            CMD_RETRIED: begin
                r.en_m[C_RETRIED] = 1'b1;
                if (i_has) begin
                    if (st != HS_PENDING) begin
                        r.en_m[C_PENDING] = 1'b1;
                    end
                    st = HS_PENDING;
                    qt = i_ts;
                    hq = 1'b1;
                end
            end
            CMD_DEAD, CMD_DROPPED: begin
                if (i_cmd == CMD_DEAD) begin
                    r.en_m[C_DEAD] = 1'b1;
                end else begin
                    r.en_m[C_DROPPED] = 1'b1;
                end
                r.en_m[C_TERMINAL] = 1'b1;
                if (i_has) begin
                    if (st == HS_PENDING) begin
                        r.en_m[C_PENDING]  = 1'b1;
                        r.dec_m[C_PENDING] = 1'b1;
                    end else if (st == HS_RUNNING) begin
                        r.en_m[C_INFLIGHT]  = 1'b1;
                        r.dec_m[C_INFLIGHT] = 1'b1;
                    end
                    if (seen) begin
                        r.gone = 1'b1;
                    end else begin
                        st = HS_DONE;
                    end
                end
            end
            default: begin
                r = '0;
            end
        endcase

        // sample counters: count, sum, maximum
        if (r.ws) begin
            r.en_m[C_WSAMP] = 1'b1;
            r.en_m[C_WSUM]  = 1'b1;
            r.en_m[C_WMAX]  = 1'b1;
        end
        if (r.rs) begin
            r.en_m[C_RSAMP] = 1'b1;
            r.en_m[C_RSUM]  = 1'b1;
            r.en_m[C_RMAX]  = 1'b1;
        end

        r.ent           = i_ent;
        r.ent.info.st   = st;
        r.ent.info.seen = seen;
        r.ent.info.hq   = hq;
        r.ent.info.hs   = hs;
        r.ent.qt        = qt;
        r.ent.stt       = stt;
        o_res           = r;
    end

endmodule
`default_nettype wire

>>> hw/rtl/transaction_lifecycle_monitor.sv
// A counter read passes through ST_RD, ST_RD_WAIT and ST_OUT; clear statistics walks
// every counter row. A lifecycle event hashes, probes, shifts entries on removal and
// then updates the totals row and the task row; one event in flight at a time.
// Probe, shift walk and counter walk are bound by the table and counter memories,
// each with one write and one registered read, one read-modify-write per counter.
// Reset: synchronous, active low; a clearing pass zeroes both memories before the
// first transfer.
`default_nettype none
`include "assert_macros.svh"
module transaction_lifecycle_monitor #(
    parameter int TABLE_SLOTS = tlm_pkg::TABLE_SLOTS_DEF,
    parameter int TASK_ROWS   = tlm_pkg::TASK_ROWS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // cmd[3:0], handle[35:4], task_req[39:36], cancelled[40], timestamp[88:41],
    // row[93:89], counter_select[98:94], zero pad[103:99]
    input  wire logic [103:0]   i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  wire logic           i_m_axis_tready,
    // tracked[0], handle_state[3:1], wait_valid[4], wait_time[52:5],
    // run_valid[53], run_time[101:54], read_data[165:102], zero pad[167:166]
    output logic [167:0]        o_m_axis_tdata
);
    import tlm_pkg::*;

    localparam int SLOT_W    = $clog2(TABLE_SLOTS);
    localparam int OCC_W     = SLOT_W + 1;
    localparam int CNT_DEPTH = (TASK_ROWS + 1) * NCNT;
    localparam int CNT_AW    = $clog2(CNT_DEPTH);
    localparam int ROW_W     = $clog2(TASK_ROWS + 1);
    localparam int LOAD_MAX  = TABLE_SLOTS * 3 / 4;
    localparam int SWEEP     = (TABLE_SLOTS > CNT_DEPTH) ? TABLE_SLOTS : CNT_DEPTH;
    localparam int SW_W      = $clog2(SWEEP);

    // memories
    t_entry       r_tbl_mem [TABLE_SLOTS];
    t_entry       r_tbl_q;
    logic [63:0]  r_cnt_mem [CNT_DEPTH];
    logic [63:0]  r_cnt_q;

    logic               tbl_we;
    logic [SLOT_W-1:0]  tbl_wa;
    t_entry             tbl_wd;
    logic [SLOT_W-1:0]  tbl_ra;
    logic               cnt_we;
    logic [CNT_AW-1:0]  cnt_wa;
    logic [63:0]        cnt_wd;
    logic [CNT_AW-1:0]  cnt_ra;

    // control
    t_state             r_state, n_state;
    logic [SW_W-1:0]    r_sw;
    logic [OCC_W-1:0]   r_occ;
    logic               r_ovalid;
    logic [167:0]       r_odata;

    // latched event
    logic [3:0]         r_cmd;
    logic [31:0]        r_h;
    logic [3:0]         r_req;
    logic               r_canc;
    logic [TS_W-1:0]    r_ts;
    logic [4:0]         r_row;
    logic [4:0]         r_sel;

    // walk state
    logic [SLOT_W-1:0]  r_i;
    logic [SLOT_W-1:0]  r_n;
    logic               r_has;
    logic               r_ins;
    t_entry             r_ent;
    logic [SLOT_W-1:0]  r_ri;
    logic [SLOT_W-1:0]  r_rj;
    logic [OCC_W-1:0]   r_rn;
    logic [4:0]         r_ccol;
    logic               r_cph;
    logic               r_wpend;
    logic [4:0]         r_wcol;
    logic [CNT_AW-1:0]  r_waddr;
    logic [NCNT-1:0]    r_en_m;
    logic [NCNT-1:0]    r_dec_m;
    logic [TS_W-1:0]    r_wms;
    logic [TS_W-1:0]    r_rms;
    logic               r_task_ok;
    logic [ROW_W-1:0]   r_ridx;

    // result fields
    logic               r_o_tracked;
    t_hstate            r_o_state;
    logic               r_o_wv;
    logic [TS_W-1:0]    r_o_wt;
    logic               r_o_rv;
    logic [TS_W-1:0]    r_o_rt;
    logic [63:0]        r_o_rdata;

    logic               accept;
    logic [3:0]         in_cmd;
    logic [31:0]        in_h;
    logic               hash_start;
    logic [31:0]        hash_key;
    logic               hash_done;
    logic [SLOT_W-1:0]  hash_home;
    t_evt_res           evt;
    logic [3:0]         tsk;
    logic               rm_shift;
    logic               rd_ok;
    logic [CNT_AW-1:0]  rd_addr;
    logic [CNT_AW-1:0]  row_base;
    logic [CNT_AW-1:0]  walk_addr;
    logic [63:0]        cnt_nv;
    logic               out_load;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign in_cmd = i_s_axis_tdata[3:0];
    assign in_h   = i_s_axis_tdata[35:4];
    assign o_s_axis_tready = (r_state == ST_IDLE);

    tlm_hash #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (hash_key),
        .o_done  (hash_done),
        .o_home  (hash_home)
    );

    tlm_evt u_evt (
        .i_cmd  (r_cmd),
        .i_has  (r_has),
        .i_canc (r_canc),
        .i_ts   (r_ts),
        .i_ent  (r_ent),
        .o_res  (evt)
    );

    // table memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[tbl_wa] <= tbl_wd;
        end
        r_tbl_q <= r_tbl_mem[tbl_ra];
    end

    // counter memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_wa] <= cnt_wd;
        end
        r_cnt_q <= r_cnt_mem[cnt_ra];
    end

    // address arithmetic, row*17 as shift and add
    assign tsk      = r_has ? r_ent.info.task_id : r_req;
    assign rd_ok    = (int'(r_row) <= TASK_ROWS) && (int'(r_sel) < NCNT);
    assign rd_addr  = (CNT_AW'(r_row) << 4) + CNT_AW'(r_row) + CNT_AW'(r_sel);
    assign row_base = r_cph ? ((CNT_AW'(r_ridx) << 4) + CNT_AW'(r_ridx)) : '0;
    assign walk_addr = row_base + CNT_AW'(r_ccol);

    // backward-shift test: home of entry j not cyclically in (i, j]
    assign rm_shift = (r_ri <= r_rj) ? (hash_home <= r_ri || hash_home > r_rj)
                                     : (hash_home <= r_ri && hash_home > r_rj);

    // counter modify
    always_comb begin
        case (t_ctr'(r_wcol))
            C_WSUM:  cnt_nv = r_cnt_q + 64'(r_wms);
            C_RSUM:  cnt_nv = r_cnt_q + 64'(r_rms);
            C_WMAX:  cnt_nv = (64'(r_wms) > r_cnt_q) ? 64'(r_wms) : r_cnt_q;
            C_RMAX:  cnt_nv = (64'(r_rms) > r_cnt_q) ? 64'(r_rms) : r_cnt_q;
            default: cnt_nv = r_dec_m[r_wcol] ? r_cnt_q - 64'd1 : r_cnt_q + 64'd1;
        endcase
    end

    assign out_load = (r_state == ST_OUT) && (!r_ovalid || i_m_axis_tready);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and memory controls
    always_comb begin
        n_state    = r_state;
        tbl_we     = 1'b0;
        tbl_wa     = r_i;
        tbl_wd     = '0;
        tbl_ra     = r_i;
        cnt_we     = 1'b0;
        cnt_wa     = r_waddr;
        cnt_wd     = '0;
        cnt_ra     = walk_addr;
        hash_start = 1'b0;
        hash_key   = in_h;
        unique case (r_state)
            ST_INIT: begin
                tbl_we = (int'(r_sw) < TABLE_SLOTS);
                tbl_wa = r_sw[SLOT_W-1:0];
                cnt_we = (int'(r_sw) < CNT_DEPTH);
                cnt_wa = r_sw[CNT_AW-1:0];
                if (int'(r_sw) == SWEEP - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (in_cmd == CMD_READ) begin
                        n_state = ST_RD;
                    end else if (in_cmd == CMD_CLEAR) begin
                        n_state = ST_CLR;
                    end else if (in_cmd > CMD_CLEAR) begin
                        n_state = ST_OUT;
                    end else if (in_h == '0) begin
                        n_state = ST_EVAL;
                    end else begin
                        hash_start = 1'b1;
                        n_state    = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    n_state = ST_PRB_RD;
                end
            end
            ST_PRB_RD: begin
                n_state = ST_PRB_CK;
            end
            ST_PRB_CK: begin
                if (r_tbl_q.key == r_h || r_tbl_q.key == '0
                    || r_n == SLOT_W'(TABLE_SLOTS - 1)) begin
                    n_state = ST_EVAL;
                end else begin
                    n_state = ST_PRB_RD;
                end
            end
            ST_EVAL: begin
                tbl_we = r_has && !evt.gone;
                tbl_wd = evt.ent;
                n_state = (r_has && evt.gone) ? ST_RM_NEXT : ST_CNT;
            end
            ST_RM_NEXT: begin
                tbl_ra = r_rj + 1'b1;
                n_state = (r_rn == OCC_W'(TABLE_SLOTS)) ? ST_RM_END : ST_RM_CK;
            end
            ST_RM_CK: begin
                if (r_tbl_q.key == '0) begin
                    n_state = ST_RM_END;
                end else begin
                    hash_start = 1'b1;
                    hash_key   = r_tbl_q.key;
                    n_state    = ST_RM_HASH;
                end
            end
            ST_RM_HASH: begin
                if (hash_done) begin
                    tbl_we  = rm_shift;
                    tbl_wa  = r_ri;
                    tbl_wd  = r_ent;
                    n_state = ST_RM_NEXT;
                end
            end
            ST_RM_END: begin
                tbl_we  = 1'b1;
                tbl_wa  = r_ri;
                n_state = ST_CNT;
            end
            ST_CNT: begin
                cnt_we = r_wpend && r_en_m[r_wcol];
                cnt_wd = cnt_nv;
                if (int'(r_ccol) == NCNT && (r_cph || !r_task_ok)) begin
                    n_state = ST_OUT;
                end
            end
            ST_CLR: begin
                cnt_we = (t_ctr'(r_ccol) != C_PENDING) && (t_ctr'(r_ccol) != C_INFLIGHT);
                cnt_wa = r_sw[CNT_AW-1:0];
                if (int'(r_sw) == CNT_DEPTH - 1) begin
                    n_state = ST_OUT;
                end
            end
            ST_RD: begin
                cnt_ra  = rd_addr;
                n_state = ST_RD_WAIT;
            end
            ST_RD_WAIT: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers: sweep counter, occupancy, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw     <= '0;
            r_occ    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == ST_INIT || r_state == ST_CLR) begin
                r_sw <= r_sw + 1'b1;
            end else begin
                r_sw <= '0;
            end
            if (r_state == ST_EVAL && r_ins && !evt.gone) begin
                r_occ <= r_occ + 1'b1;
            end else if (r_state == ST_RM_END && !r_ins && r_occ != '0) begin
                r_occ <= r_occ - 1'b1;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_cmd       <= in_cmd;
                    r_h         <= in_h;
                    r_req       <= i_s_axis_tdata[39:36];
                    r_canc      <= i_s_axis_tdata[40];
                    r_ts        <= i_s_axis_tdata[88:41];
                    r_row       <= i_s_axis_tdata[93:89];
                    r_sel       <= i_s_axis_tdata[98:94];
                    r_has       <= 1'b0;
                    r_ins       <= 1'b0;
                    r_ent       <= '0;
                    r_ccol      <= '0;
                    r_o_tracked <= 1'b0;
                    r_o_state   <= HS_NONE;
                    r_o_wv      <= 1'b0;
                    r_o_wt      <= '0;
                    r_o_rv      <= 1'b0;
                    r_o_rt      <= '0;
                    r_o_rdata   <= '0;
                end
            end
            ST_HASH: begin
                r_i <= hash_home;
                r_n <= '0;
            end
            ST_PRB_CK: begin
                if (r_tbl_q.key == r_h) begin
                    r_has <= 1'b1;
                    r_ent <= r_tbl_q;
                end else if (r_tbl_q.key == '0) begin
                    if (int'(r_occ) < LOAD_MAX) begin
                        r_has              <= 1'b1;
                        r_ins              <= 1'b1;
                        r_ent              <= '0;
                        r_ent.key          <= r_h;
                        r_ent.info.task_id <= r_req;
                    end
                end else begin
                    r_i <= r_i + 1'b1;
                    r_n <= r_n + 1'b1;
                end
            end
            ST_EVAL: begin
                r_o_tracked <= r_has;
                r_o_state   <= (r_has && !evt.gone) ? evt.ent.info.st : HS_NONE;
                r_o_wv      <= evt.ws;
                r_o_wt      <= evt.wms;
                r_o_rv      <= evt.rs;
                r_o_rt      <= evt.rms;
                r_en_m      <= evt.en_m;
                r_dec_m     <= evt.dec_m;
                r_wms       <= evt.wms;
                r_rms       <= evt.rms;
                r_task_ok   <= (int'(tsk) < TASK_ROWS);
                r_ridx      <= ROW_W'(int'(tsk) + 1);
                r_ri        <= r_i;
                r_rj        <= r_i;
                r_rn        <= '0;
                r_ccol      <= '0;
                r_cph       <= 1'b0;
                r_wpend     <= 1'b0;
            end
            ST_RM_NEXT: begin
                r_rj <= r_rj + 1'b1;
                r_rn <= r_rn + 1'b1;
            end
            ST_RM_CK: begin
                r_ent <= r_tbl_q;
            end
            ST_RM_HASH: begin
                if (hash_done && rm_shift) begin
                    r_ri <= r_rj;
                end
            end
            ST_CNT: begin
                // read column c while writing back column c-1
                r_wpend <= (int'(r_ccol) < NCNT);
                r_wcol  <= r_ccol;
                r_waddr <= walk_addr;
                if (int'(r_ccol) == NCNT) begin
                    if (!r_cph && r_task_ok) begin
                        r_cph  <= 1'b1;
                        r_ccol <= '0;
                    end
                end else begin
                    r_ccol <= r_ccol + 1'b1;
                end
            end
            ST_CLR: begin
                r_ccol <= (int'(r_ccol) == NCNT - 1) ? '0 : r_ccol + 1'b1;
            end
            ST_RD_WAIT: begin
                r_o_rdata <= rd_ok ? r_cnt_q : '0;
            end
            default: begin
                r_ccol <= r_ccol;
            end
        endcase
        if (out_load) begin
            r_odata <= {2'b00, r_o_rdata, r_o_rt, r_o_rv, r_o_wt, r_o_wv,
                        r_o_state, r_o_tracked};
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // checks
    `TLM_ASSERT(a_occ_bound, int'(r_occ) <= LOAD_MAX, "table occupancy above load limit")
    `TLM_ASSERT(a_one_item, accept |=> !o_s_axis_tready, "second transfer taken while busy")
    `TLM_ASSERT_NEVER(a_hash_stray, hash_done && !(r_state == ST_HASH || r_state == ST_RM_HASH), "hash result outside a hash wait")

endmodule
`default_nettype wire

>>> test/transaction_lifecycle_monitor_tb.sv
// ----------------------------------------------------------------------------
// Lifecycle monitor testbench
// Drives lifecycle events, counter reads and clear commands into the monitor.
// A local model of the handle table and counter rows predicts every result
// transfer, and each result is compared field by field with that prediction.
// The run has a short directed opening and then random phases with different
// sender and receiver idling. Between phases the sender waits until every
// outstanding result has arrived.
// ----------------------------------------------------------------------------
`default_nettype none
module transaction_lifecycle_monitor_tb;
    import tlm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = 64;
    localparam int ROWS      = 16;
    localparam int CYCLE_CAP = 1000000;
    localparam int POOL_SZ   = 80;

    // one expected or observed result transfer
    typedef struct {
        logic        tracked;
        logic [2:0]  hstate;
        logic        wait_ok;
        logic [47:0] wait_ms;
        logic        run_ok;
        logic [47:0] run_ms;
        logic [63:0] rdata;
    } outcome_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // cmd, handle, task_req, cancelled, timestamp, row, counter_select, pad
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // tracked, handle_state, wait_valid/time, run_valid/time, read_data, pad
    logic [167:0] m_tdata;

    transaction_lifecycle_monitor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // stimulus and expectation stores
    logic [103:0] event_queue[$];
    outcome_t     expected_results[$];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           n_errors = 0;
    int           n_accepted = 0;
    int           n_results = 0;
    int           n_reads = 0;
    int           n_refused = 0;
    int           n_cycles = 0;
    logic [47:0]  now_ms = '0;
    logic [31:0]  handle_pool[POOL_SZ];

    // model of the handle table
    logic [31:0]  tab_key[SLOTS];
    t_hstate      tab_state[SLOTS];
    logic         tab_seen[SLOTS];
    logic         tab_hq[SLOTS];
    logic         tab_hs[SLOTS];
    logic [3:0]   tab_task[SLOTS];
    logic [47:0]  tab_qt[SLOTS];
    logic [47:0]  tab_stt[SLOTS];
    int           tab_used = 0;
    logic [63:0]  counters[ROWS+1][NCNT];

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tab_key[i] = '0; tab_state[i] = HS_NONE; tab_seen[i] = 1'b0;
            tab_hq[i] = 1'b0; tab_hs[i] = 1'b0; tab_task[i] = '0;
            tab_qt[i] = '0; tab_stt[i] = '0;
        end
        for (int r = 0; r <= ROWS; r++)
            for (int c = 0; c < NCNT; c++)
                counters[r][c] = '0;
    end

    // murmur3 finaliser, masked to the table
    function automatic int home_of(input logic [31:0] h);
        logic [63:0] x;
        x = {32'd0, h};
        x = x ^ (x >> 33);
        x = x * 64'hff51afd7ed558ccd;
        x = x ^ (x >> 33);
        return int'(x[5:0]);
    endfunction

    function automatic int find_slot(input logic [31:0] h);
        int i;
        i = home_of(h);
        for (int n = 0; n < SLOTS; n++) begin
            if (tab_key[i] == h) return i;
            if (tab_key[i] == 0) return -1;
            i = (i + 1) % SLOTS;
        end
        return -1;
    endfunction

    function automatic int claim_slot(input logic [31:0] h);
        int i;
        i = home_of(h);
        if ((tab_used + 1) * 4 > SLOTS * 3) return -1;
        for (int n = 0; n < SLOTS; n++) begin
            if (tab_key[i] == 0) begin
                tab_key[i] = h; tab_state[i] = HS_NONE; tab_seen[i] = 1'b0;
                tab_hq[i] = 1'b0; tab_hs[i] = 1'b0; tab_task[i] = '0;
                tab_qt[i] = '0; tab_stt[i] = '0;
                tab_used++;
                return i;
            end
            i = (i + 1) % SLOTS;
        end
        return -1;
    endfunction

    // backward-shift deletion
    function automatic void evict_slot(input int hole);
        int i, j, k;
        i = hole;
        j = hole;
        for (int n = 0; n < SLOTS; n++) begin
            j = (j + 1) % SLOTS;
            if (tab_key[j] == 0) break;
            k = home_of(tab_key[j]);
            if ((i <= j) ? (k <= i || k > j) : (k <= i && k > j)) begin
                tab_key[i] = tab_key[j]; tab_state[i] = tab_state[j];
                tab_seen[i] = tab_seen[j]; tab_hq[i] = tab_hq[j];
                tab_hs[i] = tab_hs[j]; tab_task[i] = tab_task[j];
                tab_qt[i] = tab_qt[j]; tab_stt[i] = tab_stt[j];
                i = j;
            end
        end
        tab_key[i] = '0; tab_state[i] = HS_NONE; tab_seen[i] = 1'b0;
        tab_hq[i] = 1'b0; tab_hs[i] = 1'b0; tab_task[i] = '0;
        tab_qt[i] = '0; tab_stt[i] = '0;
        if (tab_used > 0) tab_used--;
    endfunction

    function automatic void bump(input int tr, input t_ctr c, input logic [63:0] d);
        counters[0][c] += d;
        if (tr >= 0) counters[tr+1][c] += d;
    endfunction

    function automatic void latency_sample(input int tr, input t_ctr cnt, input t_ctr sum,
                                           input t_ctr peak, input logic [47:0] ms);
        bump(tr, cnt, 64'd1);
        bump(tr, sum, {16'd0, ms});
        if ({16'd0, ms} > counters[0][peak]) counters[0][peak] = {16'd0, ms};
        if (tr >= 0 && {16'd0, ms} > counters[tr+1][peak]) counters[tr+1][peak] = {16'd0, ms};
    endfunction

    // works out the result of one accepted transfer and updates the model
    function automatic void predict_event(input logic [103:0] d);
        logic [3:0]  cmd;
        logic [31:0] h;
        logic [3:0]  task_id;
        logic        canc, seen, hq, hs, gone;
        logic [47:0] ts, qt, stt, ms;
        logic [4:0]  row, sel;
        int          slot, tr;
        t_hstate     st;
        outcome_t    r;
        cmd = d[3:0]; h = d[35:4]; canc = d[40]; ts = d[88:41];
        row = d[93:89]; sel = d[98:94];
        r = '{default: '0};
        slot = -1; gone = 1'b0;
        st = HS_NONE; seen = 1'b0; hq = 1'b0; hs = 1'b0; qt = '0; stt = '0;
        if (cmd == CMD_READ) begin
            if (row <= ROWS && sel < NCNT) r.rdata = counters[row][sel];
            n_reads++;
            expected_results.push_back(r);
            return;
        end
        if (cmd == CMD_CLEAR) begin
            for (int i = 0; i <= ROWS; i++)
                for (int c = 0; c < NCNT; c++)
                    if (c != C_PENDING && c != C_INFLIGHT) counters[i][c] = '0;
            expected_results.push_back(r);
            return;
        end
        if (cmd > CMD_CLEAR) begin
            expected_results.push_back(r);
            return;
        end
        if (h != 0) slot = find_slot(h);
        task_id = (slot >= 0) ? tab_task[slot] : d[39:36];
        tr = (task_id < ROWS) ? int'(task_id) : -1;
        if (slot < 0 && h != 0) begin
            slot = claim_slot(h);
            if (slot >= 0) tab_task[slot] = task_id;
            else n_refused++;
        end
        if (slot >= 0) begin
            st = tab_state[slot]; seen = tab_seen[slot];
            hq = tab_hq[slot]; hs = tab_hs[slot];
            qt = tab_qt[slot]; stt = tab_stt[slot];
            r.tracked = 1'b1;
        end
        case (cmd)
            CMD_QUEUED: begin
                bump(tr, C_QUEUED, 64'd1);
                if (slot >= 0) begin
                    seen = 1'b1;
                    if (!hq && hs) begin
                        ms = (stt > ts) ? stt - ts : '0;
                        latency_sample(tr, C_WSAMP, C_WSUM, C_WMAX, ms);
                        r.wait_ok = 1'b1; r.wait_ms = ms;
                    end
                    if (st == HS_DONE) gone = 1'b1;
                    else begin
                        if (st == HS_NONE) begin
                            st = HS_PENDING;
                            bump(tr, C_PENDING, 64'd1);
                        end
                        if (!hq) begin qt = ts; hq = 1'b1; end
                    end
                end
            end
            CMD_STARTED: begin
                bump(tr, C_STARTED, 64'd1);
                if (slot >= 0) begin
                    if (st == HS_PENDING) bump(tr, C_PENDING, '1);
                    st = HS_RUNNING; stt = ts; hs = 1'b1;
                    bump(tr, C_INFLIGHT, 64'd1);
                    if (hq && ts >= qt) begin
                        ms = ts - qt;
                        latency_sample(tr, C_WSAMP, C_WSUM, C_WMAX, ms);
                        r.wait_ok = 1'b1; r.wait_ms = ms;
                    end
                end
            end
            CMD_FINISHED, CMD_FAILED: begin
                if (cmd == CMD_FINISHED) begin
                    bump(tr, C_FINISHED, 64'd1);
                    bump(tr, C_TERMINAL, 64'd1);
                end else begin
                    bump(tr, C_FAILED, 64'd1);
                    if (canc) begin
                        bump(tr, C_CANCELLED, 64'd1);
                        bump(tr, C_TERMINAL, 64'd1);
                    end
                end
                if (slot >= 0) begin
                    if (st == HS_RUNNING) begin
                        bump(tr, C_INFLIGHT, '1);
                        if (hs && ts >= stt) begin
                            ms = ts - stt;
                            latency_sample(tr, C_RSAMP, C_RSUM, C_RMAX, ms);
                            r.run_ok = 1'b1; r.run_ms = ms;
                        end
                    end else if (cmd == CMD_FAILED && st == HS_PENDING) begin
                        bump(tr, C_PENDING, '1);
                    end
                    if (cmd == CMD_FAILED) st = HS_LIMBO;
                    if (cmd == CMD_FINISHED || canc) begin
                        if (seen) gone = 1'b1;
                        else st = HS_DONE;
                    end
                end
            end
            CMD_RETRIED: begin
                bump(tr, C_RETRIED, 64'd1);
                if (slot >= 0) begin
                    if (st != HS_PENDING) bump(tr, C_PENDING, 64'd1);
                    st = HS_PENDING; qt = ts; hq = 1'b1;
                end
            end
            default: begin
                bump(tr, (cmd == CMD_DEAD) ? C_DEAD : C_DROPPED, 64'd1);
                bump(tr, C_TERMINAL, 64'd1);
                if (slot >= 0) begin
                    if (st == HS_PENDING) bump(tr, C_PENDING, '1);
                    else if (st == HS_RUNNING) bump(tr, C_INFLIGHT, '1);
                    if (seen) gone = 1'b1;
                    else st = HS_DONE;
                end
            end
        endcase
        if (slot >= 0) begin
            if (gone) begin
                evict_slot(slot);
            end else begin
                tab_state[slot] = st; tab_seen[slot] = seen;
                tab_hq[slot] = hq; tab_hs[slot] = hs;
                tab_qt[slot] = qt; tab_stt[slot] = stt;
                r.hstate = st;
            end
        end
        expected_results.push_back(r);
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
        n_errors++;
    endtask

    // ---------------- stimulus helpers ----------------
    function automatic logic [47:0] next_ts();
        if ($urandom_range(99) < 8) return {$urandom(), $urandom()} & 48'hFFFF_FFFF_FFFF;
        now_ms = now_ms + 48'($urandom_range(0, 2000));
        return now_ms;
    endfunction

    function automatic void push_event(input t_cmd cmd, input logic [31:0] h,
                                       input logic [3:0] req, input logic canc,
                                       input logic [47:0] ts);
        event_queue.push_back({5'd0, 5'($urandom()), 5'($urandom()), ts, canc, req, h,
                               4'(cmd)});
    endfunction

    function automatic void push_read(input logic [4:0] row, input logic [4:0] sel);
        event_queue.push_back({5'd0, sel, row, 48'($urandom()), 1'($urandom()),
                               4'($urandom()), $urandom(), 4'(CMD_READ)});
    endfunction

    function automatic logic [31:0] pick_handle(input int pool);
        return handle_pool[$urandom_range(0, pool - 1)];
    endfunction

    // a mostly well-formed lifecycle for one handle, sometimes out of order
    function automatic void push_lifecycle(input logic [31:0] h);
        logic [3:0] req;
        int         fate;
        req = 4'($urandom());
        if ($urandom_range(99) < 15) begin
            push_event(t_cmd'($urandom_range(2, 6)), h, req, 1'($urandom()), next_ts());
            push_event(CMD_QUEUED, h, req, 1'b0, next_ts());
            return;
        end
        push_event(CMD_QUEUED, h, req, 1'b0, next_ts());
        if ($urandom_range(99) < 80) push_event(CMD_STARTED, h, req, 1'b0, next_ts());
        if ($urandom_range(99) < 25) begin
            push_event(CMD_FAILED, h, req, 1'b0, next_ts());
            push_event(CMD_RETRIED, h, req, 1'b0, next_ts());
            push_event(CMD_STARTED, h, req, 1'b0, next_ts());
        end
        fate = $urandom_range(0, 9);
        case (fate)
            0, 1, 2, 3: push_event(CMD_FINISHED, h, req, 1'b0, next_ts());
            4:          push_event(CMD_FAILED, h, req, 1'b1, next_ts());
            5:          push_event(CMD_DEAD, h, req, 1'b0, next_ts());
            6:          push_event(CMD_DROPPED, h, req, 1'b0, next_ts());
            default:    ;  // left in the table
        endcase
    endfunction

    function automatic void push_noise(input int pool);
        logic [31:0] h;
        int          pick;
        pick = $urandom_range(0, 9);
        h = (pick == 0) ? 32'd0 : (pick == 1) ? $urandom() : pick_handle(pool);
        if ($urandom_range(99) < 40)
            push_read(5'($urandom_range(0, 17)), 5'($urandom_range(0, 17)));
        else if ($urandom_range(99) < 5)
            push_read(5'($urandom()), 5'($urandom()));
        else
            event_queue.push_back({5'd0, 5'($urandom()), 5'($urandom()), next_ts(),
                                   1'($urandom()), 4'($urandom()), h,
                                   4'($urandom_range(0, 15))});
    endfunction

    task automatic drain();
        while (event_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_event(s_tdata);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= event_queue.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        outcome_t want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    report("unexpected transfer", m_tdata[63:0], '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[0] !== want.tracked)
                        report("tracked", m_tdata[0], want.tracked);
                    if (m_tdata[3:1] !== want.hstate)
                        report("handle_state", m_tdata[3:1], want.hstate);
                    if (m_tdata[4] !== want.wait_ok)
                        report("wait_valid", m_tdata[4], want.wait_ok);
                    if (m_tdata[52:5] !== want.wait_ms)
                        report("wait_time", m_tdata[52:5], want.wait_ms);
                    if (m_tdata[53] !== want.run_ok)
                        report("run_valid", m_tdata[53], want.run_ok);
                    if (m_tdata[101:54] !== want.run_ms)
                        report("run_time", m_tdata[101:54], want.run_ms);
                    if (m_tdata[165:102] !== want.rdata)
                        report("read_data", m_tdata[165:102], want.rdata);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------- sequence ----------------
    initial begin
        int send_pct[4];
        int recv_pct[4];
        int target;
        send_pct = '{0, 60, 0, 30};
        recv_pct = '{0, 0, 60, 30};
        for (int i = 0; i < POOL_SZ; i++) handle_pool[i] = $urandom() | 32'd1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening: normal flow, early terminals, extremes, reads, clear
        push_event(CMD_QUEUED, 32'd1, 4'd0, 1'b0, 48'd0);
        push_event(CMD_STARTED, 32'd1, 4'd0, 1'b0, 48'd5);
        push_event(CMD_FINISHED, 32'd1, 4'd0, 1'b0, 48'd20);
        push_event(CMD_FINISHED, 32'hFFFF_FFFF, 4'd15, 1'b0, 48'd30);
        push_event(CMD_QUEUED, 32'hFFFF_FFFF, 4'd3, 1'b0, 48'd40);
        push_event(CMD_STARTED, 32'd7, 4'd2, 1'b0, 48'hFFFF_FFFF_FFFF);
        push_event(CMD_QUEUED, 32'd7, 4'd2, 1'b0, 48'd10);
        push_event(CMD_FAILED, 32'd7, 4'd2, 1'b0, 48'd0);
        push_event(CMD_RETRIED, 32'd7, 4'd2, 1'b0, 48'd50);
        push_event(CMD_FAILED, 32'd7, 4'd2, 1'b1, 48'd60);
        push_event(CMD_QUEUED, 32'd9, 4'd5, 1'b0, 48'd70);
        push_event(CMD_DEAD, 32'd9, 4'd5, 1'b0, 48'd80);
        push_event(CMD_DROPPED, 32'd11, 4'd6, 1'b0, 48'd90);
        push_event(CMD_QUEUED, 32'd0, 4'd4, 1'b0, 48'd95);
        event_queue.push_back({5'd0, 5'h1F, 5'h1F, 48'hFFFF_FFFF_FFFF, 1'b1, 4'hF,
                               32'hFFFF_FFFF, 4'hF});
        push_read(5'd0, 5'd0);
        push_read(5'd1, 5'd16);
        push_read(5'd16, 5'd13);
        push_read(5'd0, 5'd9);
        push_read(5'd31, 5'd31);
        push_read(5'd17, 5'd0);
        event_queue.push_back({99'd0, 4'(CMD_CLEAR)});
        push_read(5'd0, 5'd0);
        push_read(5'd0, 5'd9);
        push_read(5'd3, 5'd10);
        drain();

        // random phases under different idling
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_pct[ph];
            recv_idle_pct = recv_pct[ph];
            target = n_accepted + 150;
            if (ph == 1) begin
                // push inserts past the table's load limit, then drop those handles again
                for (int i = 0; i < 55; i++)
                    push_event(CMD_QUEUED, 32'h8000_0000 + i, 4'($urandom()), 1'b0, next_ts());
                for (int i = 0; i < 55; i++)
                    push_event(CMD_DROPPED, 32'h8000_0000 + i, 4'd0, 1'b0, next_ts());
            end
            while (n_accepted + event_queue.size() < target) begin
                if ($urandom_range(99) < 65)
                    push_lifecycle(pick_handle(ph == 2 ? POOL_SZ : 20));
                else
                    push_noise(ph == 2 ? POOL_SZ : 20);
                if ($urandom_range(99) < 2) event_queue.push_back({99'd0, 4'(CMD_CLEAR)});
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        $display("Ran %0d transfers (%0d counter reads), %0d results checked,",
                 n_accepted, n_reads, n_results);
        $display("%0d inserts refused at the load limit, %0d mismatches.",
                 n_refused, n_errors);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
